// ===== sv/gbsc_pkg.sv =====
// Shared widths, register codes and control structs for the gyro bias calibrator.
package gbsc_pkg;

   localparam int DATA_WIDTH      = 16;
   localparam int LIMIT_WIDTH     = 15;
   localparam int SUM_WIDTH       = 24;
   localparam int MAG_WIDTH       = 23;
   localparam int RECIP_WIDTH     = MAG_WIDTH + 1;
   localparam int COUNT_WIDTH     = 7;
   localparam int MODE_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int LANES           = 3;

   localparam int DEFAULT_SAMPLE_COUNT = 100;

   localparam logic [LIMIT_WIDTH-1:0] GYRO_LIMIT_RESET  = LIMIT_WIDTH'(500);
   localparam logic [LIMIT_WIDTH-1:0] ACCEL_LIMIT_RESET = LIMIT_WIDTH'(10);
   localparam logic [LIMIT_WIDTH-1:0] MAG_LIMIT_RESET   = LIMIT_WIDTH'(5);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GYRO_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEL_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAG_LIMIT   = 2'd2;

   localparam logic [MODE_WIDTH-1:0] MODE_IDLE   = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_COUNT  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_FINISH = 2'd2;

   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] gyro;
      logic [LIMIT_WIDTH-1:0] accel;
      logic [LIMIT_WIDTH-1:0] mag;
   } limits_type;

   // per-word commands from the merge/mode controller to the axis lanes
   typedef struct packed {
      logic take;
      logic idle;
      logic clear;
      logic accum;
   } lane_ctrl_type;

   // stage enables for the per-lane bias divider pipe
   typedef struct packed {
      logic load1;
      logic load2;
      logic commit;
   } div_en_type;

endpackage

// ===== sv/gbsc_lane.sv =====
// One axis lane: reference latches, stillness compares and gyro accumulator.
module gbsc_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gbsc_pkg::lane_ctrl_type               ctrl,
   input  gbsc_pkg::limits_type                  limits,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0] accel,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0] gyro,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0] mag,
   output logic                                  still,
   output logic [gbsc_pkg::SUM_WIDTH-1:0]        sum
);
   import gbsc_pkg::*;

   logic [DATA_WIDTH-1:0] ref_accel_ff, ref_accel_in;
   logic [DATA_WIDTH-1:0] ref_mag_ff, ref_mag_in;
   logic [SUM_WIDTH-1:0]  sum_ff, sum_in;

   logic [DATA_WIDTH:0] gyro_ext, gyro_abs;
   logic [DATA_WIDTH:0] accel_diff, accel_abs;
   logic [DATA_WIDTH:0] mag_diff, mag_abs;
   logic [DATA_WIDTH-1:0] accel_ref_use, mag_ref_use;

   always_comb begin
      // in idle the reference is the current word itself
      accel_ref_use = ctrl.idle ? accel : ref_accel_ff;
      mag_ref_use   = ctrl.idle ? mag : ref_mag_ff;

      gyro_ext   = {gyro[DATA_WIDTH-1], gyro};
      gyro_abs   = gyro_ext[DATA_WIDTH] ? ((DATA_WIDTH+1)'(0) - gyro_ext) : gyro_ext;
      accel_diff = {accel[DATA_WIDTH-1], accel}
                 - {accel_ref_use[DATA_WIDTH-1], accel_ref_use};
      accel_abs  = accel_diff[DATA_WIDTH] ? ((DATA_WIDTH+1)'(0) - accel_diff) : accel_diff;
      mag_diff   = {mag[DATA_WIDTH-1], mag} - {mag_ref_use[DATA_WIDTH-1], mag_ref_use};
      mag_abs    = mag_diff[DATA_WIDTH] ? ((DATA_WIDTH+1)'(0) - mag_diff) : mag_diff;

      still = (gyro_abs < (DATA_WIDTH+1)'(limits.gyro))
           && (accel_abs < (DATA_WIDTH+1)'(limits.accel))
           && (mag_abs < (DATA_WIDTH+1)'(limits.mag));

      ref_accel_in = ref_accel_ff;
      ref_mag_in   = ref_mag_ff;
      sum_in       = sum_ff;
      if (ctrl.idle) begin
         ref_accel_in = accel;
         ref_mag_in   = mag;
      end
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.accum) begin
         sum_in = sum_ff + {{(SUM_WIDTH-DATA_WIDTH){gyro[DATA_WIDTH-1]}}, gyro};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_accel_ff <= '0;
         ref_mag_ff   <= '0;
         sum_ff       <= '0;
      end else if (ctrl.take) begin
         ref_accel_ff <= ref_accel_in;
         ref_mag_ff   <= ref_mag_in;
         sum_ff       <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== sv/gbsc_ctrl.sv =====
// Merges lane stillness and runs the calibration mode machine and still counter.
module gbsc_ctrl #(
   parameter int SAMPLE_COUNT = gbsc_pkg::DEFAULT_SAMPLE_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              take,
   input  logic [gbsc_pkg::LANES-1:0]        lane_still,
   output gbsc_pkg::lane_ctrl_type           lane_ctrl,
   output logic [gbsc_pkg::MODE_WIDTH-1:0]   mode_next,
   output logic                              finish
);
   import gbsc_pkg::*;

   typedef enum logic [MODE_WIDTH-1:0] {
      ST_IDLE   = MODE_IDLE,
      ST_COUNT  = MODE_COUNT,
      ST_FINISH = MODE_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in, count_inc;
   logic                   all_still;

   always_comb begin
      all_still = &lane_still;
      count_inc = count_ff + COUNT_WIDTH'(1);
      state_in  = state_ff;
      count_in  = count_ff;
      lane_ctrl.take  = take;
      lane_ctrl.idle  = (state_ff == ST_IDLE);
      lane_ctrl.clear = 1'b0;
      lane_ctrl.accum = 1'b0;
      finish          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (all_still) begin
               lane_ctrl.clear = 1'b1;
               count_in        = '0;
               state_in        = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (all_still) begin
               lane_ctrl.accum = 1'b1;
               count_in        = count_inc;
               if (count_inc == COUNT_WIDTH'(SAMPLE_COUNT)) begin
                  state_in = ST_FINISH;
               end
            end else begin
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: begin
            finish   = 1'b1;
            count_in = '0;
            state_in = ST_IDLE;
         end
         default: begin
            count_in = '0;
            state_in = ST_IDLE;
         end
      endcase
      mode_next = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else if (take) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/gbsc_div.sv =====
// Per-lane bias divider: sum / SAMPLE_COUNT by reciprocal multiply, then the bias register.
module gbsc_div #(
   parameter int SAMPLE_COUNT = gbsc_pkg::DEFAULT_SAMPLE_COUNT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gbsc_pkg::div_en_type                  en,
   input  logic [gbsc_pkg::SUM_WIDTH-1:0]        sum,
   output logic signed [gbsc_pkg::DATA_WIDTH-1:0] bias
);
   import gbsc_pkg::*;

   // floor(m * RECIP >> SHIFT) == floor(m / N) for all m < 2**MAG_WIDTH
   localparam int SHIFT      = MAG_WIDTH + $clog2(SAMPLE_COUNT);
   localparam int PROD_WIDTH = MAG_WIDTH + RECIP_WIDTH;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);
   localparam logic [RECIP_WIDTH-1:0] RECIP = RECIP_FULL[RECIP_WIDTH-1:0];

   logic                   neg1_ff, neg2_ff;
   logic [MAG_WIDTH-1:0]   mag1_ff;
   logic [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic [SUM_WIDTH-1:0]   sum_abs;
   logic [DATA_WIDTH-1:0]  quot;
   logic [DATA_WIDTH-1:0]  bias_ff, bias_in;

   always_comb begin
      sum_abs = sum[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - sum) : sum;
      prod_in = PROD_WIDTH'(mag1_ff) * PROD_WIDTH'(RECIP);
      quot    = prod_ff[SHIFT +: DATA_WIDTH];
      bias_in = neg2_ff ? (DATA_WIDTH'(0) - quot) : quot;
   end

   always_ff @(posedge clock) begin
      if (en.load1) begin
         neg1_ff <= sum[SUM_WIDTH-1];
         mag1_ff <= sum_abs[MAG_WIDTH-1:0];
      end
      if (en.load2) begin
         neg2_ff <= neg1_ff;
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else if (en.commit) begin
         bias_ff <= bias_in;
      end
   end

   assign bias = bias_ff;

endmodule

// ===== sv/gyro_bias_static_calibrator.sv =====
// An accepted req word passes v1_ff, v2_ff and rsp_valid_ff to rsp_valid; one word per cycle while rsp_ready holds.
// The rate is set by the mode/still-count update and per-axis accumulators, updated once per accepted word.
// The bias divide (reciprocal multiply) runs in two pipelined stages behind the accept stage.
// A stalled rsp side backs up through the pipe; req_ready drops only when all stages are full.
// Synchronous active-high reset: mode idle, sums/refs/bias zero, limits 500/10/5.
module gyro_bias_static_calibrator #(
   parameter int SAMPLE_COUNT = gbsc_pkg::DEFAULT_SAMPLE_COUNT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0]    req_accel_x,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0]    req_accel_y,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0]    req_accel_z,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0]    req_gyro_x,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0]    req_gyro_y,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0]    req_gyro_z,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0]    req_mag_x,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0]    req_mag_y,
   input  logic signed [gbsc_pkg::DATA_WIDTH-1:0]    req_mag_z,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [gbsc_pkg::DATA_WIDTH-1:0]    rsp_bias_x,
   output logic signed [gbsc_pkg::DATA_WIDTH-1:0]    rsp_bias_y,
   output logic signed [gbsc_pkg::DATA_WIDTH-1:0]    rsp_bias_z,
   output logic                                      rsp_bias_updated,
   output logic [gbsc_pkg::MODE_WIDTH-1:0]           rsp_mode,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [gbsc_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [gbsc_pkg::CSR_DATA_WIDTH-1:0]       csr_data
);
   import gbsc_pkg::*;

   limits_type limits_ff;

   logic                    v1_ff, v2_ff, rsp_valid_ff;
   logic                    upd1_ff, upd2_ff, rsp_upd_ff;
   logic [MODE_WIDTH-1:0]   mode1_ff, mode2_ff, rsp_mode_ff;
   logic                    ready1, ready2, ready3, take;

   logic signed [DATA_WIDTH-1:0] accel_arr [LANES];
   logic signed [DATA_WIDTH-1:0] gyro_arr  [LANES];
   logic signed [DATA_WIDTH-1:0] mag_arr   [LANES];
   logic signed [DATA_WIDTH-1:0] bias_arr  [LANES];
   logic [SUM_WIDTH-1:0]         sum_arr   [LANES];
   logic [LANES-1:0]             lane_still;

   lane_ctrl_type         lane_ctrl;
   div_en_type            div_en;
   logic [MODE_WIDTH-1:0] mode_next;
   logic                  finish;

   assign ready3    = !rsp_valid_ff || rsp_ready;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_ready = ready1;
   assign take      = req_valid && ready1;
   assign csr_ready = 1'b1;

   assign accel_arr[0] = req_accel_x;
   assign accel_arr[1] = req_accel_y;
   assign accel_arr[2] = req_accel_z;
   assign gyro_arr[0]  = req_gyro_x;
   assign gyro_arr[1]  = req_gyro_y;
   assign gyro_arr[2]  = req_gyro_z;
   assign mag_arr[0]   = req_mag_x;
   assign mag_arr[1]   = req_mag_y;
   assign mag_arr[2]   = req_mag_z;

   always_comb begin
      div_en.load1  = take;
      div_en.load2  = v1_ff && ready2;
      div_en.commit = v2_ff && ready3 && upd2_ff;
   end

   gbsc_ctrl #(
      .SAMPLE_COUNT(SAMPLE_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .lane_still (lane_still),
      .lane_ctrl  (lane_ctrl),
      .mode_next  (mode_next),
      .finish     (finish)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      gbsc_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .limits (limits_ff),
         .accel  (accel_arr[g]),
         .gyro   (gyro_arr[g]),
         .mag    (mag_arr[g]),
         .still  (lane_still[g]),
         .sum    (sum_arr[g])
      );

      gbsc_div #(
         .SAMPLE_COUNT(SAMPLE_COUNT)
      ) u_div (
         .clock (clock),
         .reset (reset),
         .en    (div_en),
         .sum   (sum_arr[g]),
         .bias  (bias_arr[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.gyro  <= GYRO_LIMIT_RESET;
         limits_ff.accel <= ACCEL_LIMIT_RESET;
         limits_ff.mag   <= MAG_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GYRO_LIMIT:  limits_ff.gyro  <= csr_data[LIMIT_WIDTH-1:0];
            CSR_ACCEL_LIMIT: limits_ff.accel <= csr_data[LIMIT_WIDTH-1:0];
            CSR_MAG_LIMIT:   limits_ff.mag   <= csr_data[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= req_valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         upd1_ff  <= finish;
         mode1_ff <= mode_next;
      end
      if (v1_ff && ready2) begin
         upd2_ff  <= upd1_ff;
         mode2_ff <= mode1_ff;
      end
      if (v2_ff && ready3) begin
         rsp_upd_ff  <= upd2_ff;
         rsp_mode_ff <= mode2_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bias_x       = bias_arr[0];
   assign rsp_bias_y       = bias_arr[1];
   assign rsp_bias_z       = bias_arr[2];
   assign rsp_bias_updated = rsp_upd_ff;
   assign rsp_mode         = rsp_mode_ff;

endmodule
